@@ design/mcatc_pkg.sv @@
// Shared types and constants for the multi-code all-targets check.
// Used by mcatc_parse and multi_code_all_targets_check; no dependencies.
package mcatc_pkg;

    localparam int DEF_NUM_TARGETS = 4;
    localparam int TARGET_W        = 32;
    localparam int ACC_W           = 33;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int NUM_TARGET_REGS = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BASE  = 3'd1;

    localparam logic [2:0] TARGET_COUNT_RST = 3'd1;

    localparam logic [1:0] PH_EMPTY = 2'd0;
    localparam logic [1:0] PH_SPACE = 2'd1;
    localparam logic [1:0] PH_SIGN  = 2'd2;
    localparam logic [1:0] PH_DIGIT = 2'd3;

    localparam logic [1:0] RES_FALSE   = 2'd0;
    localparam logic [1:0] RES_MATCHED = 2'd1;
    localparam logic [1:0] RES_MISSING = 2'd2;
    localparam logic [1:0] RES_INVALID = 2'd3;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    localparam logic [ACC_W-1:0] ACC_SAT     = 33'h1_0000_0000;
    localparam logic [ACC_W-1:0] LIMIT_POS   = 33'h0_7FFF_FFFF;
    localparam logic [ACC_W-1:0] LIMIT_NEG   = 33'h0_8000_0000;

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_valid;
        logic       end_of_record;
        logic       record_missing;
    } t_item;

    typedef struct packed {
        logic [ACC_W-1:0] accum;
        logic [1:0]       phase;
        logic             neg;
        logic             inv;
    } t_comp;

    typedef struct packed {
        logic [2:0] count;
        logic       inv;
        logic       missing;
    } t_rec;

    typedef struct packed {
        t_comp      comp;
        t_rec       rec;
        logic [1:0] result;
    } t_step;

    localparam t_comp COMP_CLEAR = '{accum: '0, phase: PH_EMPTY, neg: 1'b0, inv: 1'b0};
    localparam t_rec  REC_CLEAR  = '{count: 3'd0, inv: 1'b0, missing: 1'b0};

endpackage

@@ design/multi_code_all_targets_check.sv @@
// Top level of the multi-code all-targets check: beat registers, config, state.
// Depends on mcatc_pkg and mcatc_parse.
//
//  channel  direction  handshake               payload
//  in       sink       i_in_valid / o_in_stall  char_code, char_valid, end_of_record,
//                                               record_missing
//  out      source     o_out_valid / i_out_stall record_result
//  cfg      sink       i_cfg_we                 i_cfg_index, i_cfg_data
//
// One beat per cycle sustained unless an end-of-record beat waits on an output stall.
// A record's last beat goes through the input register, parse step and result register.
// Synchronous active-low reset clears parse state, flags, targets (0) and target_count (1).
// An output stall holds the result; only an end-of-record beat waits behind it.
module multi_code_all_targets_check #(
    parameter int NUM_TARGETS = mcatc_pkg::DEF_NUM_TARGETS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_char_code,
    input  logic                              i_char_valid,
    input  logic                              i_end_of_record,
    input  logic                              i_record_missing,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_record_result,
    input  logic                              i_cfg_we,
    input  logic [mcatc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mcatc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mcatc_pkg::*;

    logic                r_in_valid;
    t_item               r_in;
    logic                r_out_valid;
    logic [1:0]          r_out_result;
    t_comp               r_comp;
    t_rec                r_rec;
    logic [2:0]          r_target_count;
    logic [TARGET_W-1:0] r_targets [NUM_TARGETS];

    t_step               n_step;
    logic                out_free;
    logic                proc;
    logic                in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && (!r_in.end_of_record || out_free);
    assign o_in_stall = r_in_valid && !proc;
    assign in_take    = i_in_valid && !o_in_stall;

    mcatc_parse #(
        .NUM_TARGETS (NUM_TARGETS)
    ) u_parse (
        .i_item         (r_in),
        .i_comp         (r_comp),
        .i_rec          (r_rec),
        .i_target_count (r_target_count),
        .i_targets      (r_targets),
        .o_next         (n_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= '{char_code: i_char_code, char_valid: i_char_valid,
                      end_of_record: i_end_of_record, record_missing: i_record_missing};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp <= COMP_CLEAR;
            r_rec  <= REC_CLEAR;
        end else if (proc) begin
            r_comp <= n_step.comp;
            r_rec  <= n_step.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in.end_of_record) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in.end_of_record) begin
            r_out_result <= n_step.result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_record_result = r_out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_count <= TARGET_COUNT_RST;
        end else if (i_cfg_we && i_cfg_index == CFG_TARGET_COUNT) begin
            r_target_count <= i_cfg_data[2:0];
        end
    end

    for (genvar j = 0; j < NUM_TARGETS; j++) begin : g_target
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_targets[j] <= '0;
            end else if (j < NUM_TARGET_REGS && i_cfg_we &&
                         i_cfg_index == CFG_IDX_W'(int'(CFG_TARGET_BASE) + j)) begin
                r_targets[j] <= i_cfg_data[TARGET_W-1:0];
            end
        end
    end

    a_end_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.end_of_record |=> r_out_valid)
        else $error("end-of-record beat did not load the result register");

    a_end_clears_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.end_of_record |=> r_rec.count == 3'd0 && !r_rec.inv && !r_rec.missing
            && r_comp.phase == PH_EMPTY)
        else $error("record state not cleared after end of record");

    a_missing_wins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.end_of_record && (r_in.record_missing || r_rec.missing)
            |=> r_out_result == RES_MISSING)
        else $error("missing record not reported as missing");

    a_held_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !proc |=> r_in_valid && $stable(r_in))
        else $error("held input beat was lost or overwritten");

endmodule

@@ design/mcatc_parse.sv @@
// Next-state logic for one beat: character parse, component close and result.
// Depends on mcatc_pkg.
module mcatc_parse #(
    parameter int NUM_TARGETS = mcatc_pkg::DEF_NUM_TARGETS
) (
    input  mcatc_pkg::t_item             i_item,
    input  mcatc_pkg::t_comp             i_comp,
    input  mcatc_pkg::t_rec              i_rec,
    input  logic [2:0]                   i_target_count,
    input  logic [mcatc_pkg::TARGET_W-1:0] i_targets [NUM_TARGETS],
    output mcatc_pkg::t_step             o_next
);
    import mcatc_pkg::*;

    function automatic logic [TARGET_W-1:0] comp_value(t_comp c);
        logic [TARGET_W-1:0] mag;
        mag = c.accum[TARGET_W-1:0];
        return c.neg ? (~mag + 32'd1) : mag;
    endfunction

    function automatic t_rec close_comp(t_comp c, t_rec r, logic [2:0] used, logic hit);
        t_rec o;
        logic bad;
        o = r;
        bad = c.inv || c.phase == PH_SPACE || c.phase == PH_SIGN ||
              (c.phase == PH_DIGIT && c.accum > (c.neg ? LIMIT_NEG : LIMIT_POS));
        if (r.count < used && !r.inv) begin
            if (bad) begin
                o.inv = 1'b1;
            end else if (hit) begin
                o.count = r.count + 3'd1;
            end
        end
        return o;
    endfunction

    logic [2:0]           used;
    t_comp                cur;
    logic                 close_a;
    logic                 hit_a;
    logic                 hit_b;
    logic [ACC_W+3:0]     acc_next;
    logic [7:0]           c;
    t_rec                 rec_a;
    t_rec                 rec_b;
    logic [TARGET_W-1:0]  val_a;
    logic [TARGET_W-1:0]  val_b;

    always_comb begin
        if (i_target_count == 3'd0) begin
            used = 3'd1;
        end else if (int'(i_target_count) > NUM_TARGETS) begin
            used = 3'(NUM_TARGETS);
        end else begin
            used = i_target_count;
        end
    end

    always_comb begin
        c        = i_item.char_code;
        cur      = i_comp;
        close_a  = 1'b0;
        acc_next = {1'b0, i_comp.accum, 3'b000} + {3'b000, i_comp.accum, 1'b0}
                 + {29'd0, 8'(c - CH_ZERO)};
        if (i_item.char_valid) begin
            if (c == CH_SEMI) begin
                close_a = 1'b1;
                cur     = COMP_CLEAR;
            end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                if (i_comp.phase <= PH_SPACE) begin
                    cur.phase = PH_SPACE;
                end else begin
                    cur.inv = 1'b1;
                end
            end else if (c == CH_PLUS || c == CH_MINUS) begin
                if (i_comp.phase <= PH_SPACE) begin
                    cur.phase = PH_SIGN;
                    cur.neg   = (c == CH_MINUS);
                end else begin
                    cur.inv = 1'b1;
                end
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
                cur.phase = PH_DIGIT;
                cur.accum = (acc_next > {4'd0, ACC_SAT}) ? ACC_SAT : acc_next[ACC_W-1:0];
            end else begin
                cur.inv = 1'b1;
            end
        end
    end

    always_comb begin
        hit_a = 1'b0;
        hit_b = 1'b0;
        val_a = comp_value(i_comp);
        val_b = comp_value(cur);
        for (int j = 0; j < NUM_TARGETS; j++) begin
            if (j < int'(used)) begin
                hit_a = hit_a | (val_a == i_targets[j]);
                hit_b = hit_b | (val_b == i_targets[j]);
            end
        end
    end

    always_comb begin
        rec_a         = close_a ? close_comp(i_comp, i_rec, used, hit_a) : i_rec;
        rec_a.missing = i_rec.missing | i_item.record_missing;
        rec_b         = close_comp(cur, rec_a, used, hit_b);
        if (rec_b.missing) begin
            o_next.result = RES_MISSING;
        end else if (rec_b.inv) begin
            o_next.result = RES_INVALID;
        end else if (rec_b.count >= used) begin
            o_next.result = RES_MATCHED;
        end else begin
            o_next.result = RES_FALSE;
        end
        if (i_item.end_of_record) begin
            o_next.comp = COMP_CLEAR;
            o_next.rec  = REC_CLEAR;
        end else begin
            o_next.comp = cur;
            o_next.rec  = rec_a;
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for multi_code_all_targets_check: drives character beats of
// semicolon-separated code records and checks every verdict against a local tracker.
// Depends on mcatc_pkg and the multi_code_all_targets_check RTL only.
module tb;
    import mcatc_pkg::*;

    localparam int NUM_T       = DEF_NUM_TARGETS;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYC  = 4;
    localparam int REPORT_MAX  = 10;

    localparam logic [7:0] NUL_CODE = 8'h00;
    localparam logic [7:0] TOP_CODE = 8'hFF;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_char_code      = '0;
    logic                  i_char_valid     = 1'b0;
    logic                  i_end_of_record  = 1'b0;
    logic                  i_record_missing = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall      = 1'b0;
    logic [1:0]            o_record_result;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    // tracker copy of registers and parse state
    logic [2:0]          cfg_count = TARGET_COUNT_RST;
    logic [TARGET_W-1:0] cfg_target [NUM_T] = '{default: '0};
    logic [TARGET_W-1:0] staged_targets [NUM_T];
    logic [ACC_W-1:0]    code_mag   = '0;
    logic [1:0]          code_phase = PH_EMPTY;
    logic                code_neg   = 1'b0;
    logic                code_bad   = 1'b0;
    logic [2:0]          hit_count  = '0;
    logic                rec_bad    = 1'b0;
    logic                rec_missing = 1'b0;

    logic [1:0] due_verdicts [$];
    logic [7:0] line_text [$];
    logic [1:0] want;

    int snd_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    int beats_sent    = 0;
    int real_items    = 0;
    int records_sent  = 0;
    int settings_used = 0;
    int verdicts_seen = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    multi_code_all_targets_check u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_char_code      (i_char_code),
        .i_char_valid     (i_char_valid),
        .i_end_of_record  (i_end_of_record),
        .i_record_missing (i_record_missing),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_record_result  (o_record_result),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    function automatic int unsigned active_targets();
        int unsigned n;
        n = cfg_count;
        if (n == 0) n = 1;
        if (n > NUM_T) n = NUM_T;
        return n;
    endfunction

    task automatic close_code();
        int unsigned      n;
        logic [ACC_W-1:0] lim;
        logic             flag;
        longint           value;
        n = active_targets();
        if (hit_count < n && !rec_bad) begin
            flag = code_bad || code_phase == PH_SPACE || code_phase == PH_SIGN;
            lim  = code_neg ? LIMIT_NEG : LIMIT_POS;
            if (code_phase == PH_DIGIT && code_mag > lim) flag = 1'b1;
            if (flag) begin
                rec_bad = 1'b1;
            end else begin
                value = code_neg ? -longint'(code_mag) : longint'(code_mag);
                for (int j = 0; j < n; j++) begin
                    if (value == longint'($signed(cfg_target[j]))) begin
                        hit_count++;
                        break;
                    end
                end
            end
        end
        code_mag   = '0;
        code_phase = PH_EMPTY;
        code_neg   = 1'b0;
        code_bad   = 1'b0;
    endtask

    task automatic take_char(logic [7:0] c);
        longint unsigned grown;
        if (c == CH_SEMI) begin
            close_code();
        end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            if (code_phase == PH_EMPTY || code_phase == PH_SPACE) code_phase = PH_SPACE;
            else code_bad = 1'b1;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            if (code_phase == PH_EMPTY || code_phase == PH_SPACE) begin
                code_phase = PH_SIGN;
                code_neg   = (c == CH_MINUS);
            end else begin
                code_bad = 1'b1;
            end
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            grown = longint'(code_mag) * 10 + longint'(c - CH_ZERO);
            if (grown > ACC_SAT) grown = ACC_SAT;
            code_mag   = grown[ACC_W-1:0];
            code_phase = PH_DIGIT;
        end else begin
            code_bad = 1'b1;
        end
    endtask

    task automatic advance_record(logic [7:0] c, logic cv, logic eor, logic miss);
        logic [1:0] verdict;
        if (cv) take_char(c);
        if (miss) rec_missing = 1'b1;
        if (eor) begin
            close_code();
            if (rec_missing) verdict = RES_MISSING;
            else if (rec_bad) verdict = RES_INVALID;
            else if (hit_count >= active_targets()) verdict = RES_MATCHED;
            else verdict = RES_FALSE;
            due_verdicts.push_back(verdict);
            hit_count   = '0;
            rec_bad     = 1'b0;
            rec_missing = 1'b0;
        end
    endtask

    // one input beat; valid stays high on return so back-to-back beats need no gap
    task automatic send_beat(logic [7:0] c, logic cv, logic eor, logic miss);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_char_code      <= c;
        i_char_valid     <= cv;
        i_end_of_record  <= eor;
        i_record_missing <= miss;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_record(c, cv, eor, miss);
        beats_sent++;
        if (cv || eor || miss) real_items++;
        @(negedge i_clk);
    endtask

    task automatic send_line(bit end_apart, int miss_at);
        int n;
        n = line_text.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 3) send_beat(8'($urandom), 1'b0, 1'b0, 1'b0);
            send_beat(line_text[i], 1'b1, (i == n - 1) && !end_apart, miss_at == i);
        end
        if (end_apart || n == 0) send_beat(8'($urandom), 1'b0, 1'b1, miss_at >= n);
        records_sent++;
    endtask

    task automatic load_text(string s);
        line_text.delete();
        for (int i = 0; i < s.len(); i++) line_text.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_verdicts.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_regs(logic [2:0] cnt, bit with_unused);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TARGET_COUNT;
        i_cfg_data  <= {29'($urandom), cnt};
        cfg_count    = cnt;
        @(negedge i_clk);
        for (int j = 0; j < NUM_TARGET_REGS; j++) begin
            i_cfg_index  <= CFG_TARGET_BASE + 3'(j);
            i_cfg_data   <= staged_targets[j];
            cfg_target[j] = staged_targets[j];
            @(negedge i_clk);
        end
        if (with_unused) begin
            for (int k = CFG_TARGET_BASE + NUM_TARGET_REGS; k < 2**CFG_IDX_W; k++) begin
                i_cfg_index <= 3'(k);
                i_cfg_data  <= $urandom;
                @(negedge i_clk);
            end
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // mostly well-formed records built around the active targets, with some noise
    task automatic send_random_record();
        int              parts;
        int              kind;
        int              start;
        int              miss_at;
        bit              end_apart;
        longint          value;
        longint unsigned mag;
        string           digits;
        line_text.delete();
        parts = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
        for (int k = 0; k < parts; k++) begin
            if (k > 0) line_text.push_back(CH_SEMI);
            start = line_text.size();
            kind  = $urandom_range(0, 99);
            if (kind >= 5 && kind < 10) begin
                if ($urandom_range(0, 1)) line_text.push_back(pick_blank());
                else line_text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            end else if (kind >= 10) begin
                if ($urandom_range(0, 6) == 0) line_text.push_back(pick_blank());
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        value = longint'($signed(cfg_target[$urandom_range(0,
                                                            active_targets() - 1)]));
                    end
                    5: value = longint'($urandom_range(0, 20)) - 10;
                    6: value = longint'($signed(32'($urandom)));
                    7: begin
                        case ($urandom_range(0, 5))
                            0: value = 64'sd2147483647;
                            1: value = -64'sd2147483648;
                            2: value = 64'sd2147483648;
                            3: value = -64'sd2147483649;
                            4: value = 64'sd4294967296;
                            default: value = 64'sd99999999999;
                        endcase
                    end
                    default: value = longint'($urandom_range(0, 999));
                endcase
                if (value < 0) begin
                    line_text.push_back(CH_MINUS);
                    mag = -value;
                end else begin
                    if ($urandom_range(0, 3) == 0) line_text.push_back(CH_PLUS);
                    mag = value;
                end
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 12)) line_text.push_back(CH_ZERO);
                end
                digits = $sformatf("%0d", mag);
                for (int d = 0; d < digits.len(); d++) line_text.push_back(digits[d]);
            end
            if (kind >= 92) begin
                line_text.insert($urandom_range(start, line_text.size()),
                                 $urandom_range(0, 1) ? pick_blank() : 8'($urandom));
            end
        end
        if ($urandom_range(0, 19) == 0) line_text.push_back(CH_SEMI);
        end_apart = ($urandom_range(0, 9) < 3);
        miss_at   = ($urandom_range(0, 24) == 0) ? $urandom_range(0, line_text.size()) : -1;
        send_line(end_apart, miss_at);
    endtask

    task automatic run_records(int count);
        int goal;
        goal = real_items + count;
        while (real_items < goal) send_random_record();
    endtask

    task automatic test_parse_cases();
        send_beat(NUL_CODE, 1'b0, 1'b1, 1'b0);      // empty record
        load_text("7;");
        send_line(1'b1, -1);                        // trailing separator
        load_text("\t");
        send_line(1'b1, -1);                        // blank only
        send_beat(CH_MINUS, 1'b1, 1'b1, 1'b0);      // sign only
        send_beat(NUL_CODE, 1'b1, 1'b1, 1'b0);
        send_beat(TOP_CODE, 1'b0, 1'b1, 1'b1);
        send_beat(TOP_CODE, 1'b1, 1'b1, 1'b1);      // missing wins over invalid
        load_text("1 ");
        send_line(1'b0, -1);                        // blank after digits
        load_text("0;");
        line_text.push_back(TOP_CODE);
        send_line(1'b0, -1);                        // junk after count reached
        load_text("+5");
        send_line(1'b0, -1);
        load_text("9999999999");
        send_line(1'b0, -1);                        // overflow
    endtask

    task automatic test_target_limits();
        staged_targets = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        write_regs(3'd0, 1'b1);
        run_records(50);
        staged_targets = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
        write_regs(3'd7, 1'b0);
        run_records(50);
    endtask

    task automatic test_random_records(int count);
        for (int b = 0; b < 4; b++) begin
            for (int j = 0; j < NUM_T; j++) begin
                case ($urandom_range(0, 5))
                    0: staged_targets[j] = 32'($urandom_range(0, 20));
                    1: staged_targets[j] = -32'($urandom_range(1, 20));
                    2: staged_targets[j] = 32'h7FFF_FFFF;
                    3: staged_targets[j] = 32'h8000_0000;
                    4: staged_targets[j] = $urandom;
                    default: staged_targets[j] = staged_targets[0];
                endcase
            end
            write_regs(3'($urandom_range(0, 7)), 1'b0);
            run_records(count / 4);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            verdicts_seen++;
            if (due_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("ERROR: verdict %0d arrived with none due (got %0d)",
                             verdicts_seen, o_record_result);
                end
            end else begin
                want = due_verdicts.pop_front();
                if (o_record_result !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("ERROR: verdict %0d: expected %0d, got %0d",
                                 verdicts_seen, want, o_record_result);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        snd_idle_pct = 23;
        rcv_idle_pct = 68;
        test_parse_cases();
        test_target_limits();
        test_random_records(450);
        snd_idle_pct = 68;
        rcv_idle_pct = 23;
        test_random_records(500);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_records(500);
        settle();
        $display("Run covered %0d beats (%0d records) under %0d register settings.",
                 beats_sent, records_sent, settings_used);
        $display("Checked %0d verdicts, %0d mismatches.", verdicts_seen, mismatches);
        if (mismatches == 0 && due_verdicts.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
